// ===== sv/command_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// command_frame_parser_macros.svh
// Assertion macros for the command frame parser checker.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_PARSER_MACROS_SVH
`define COMMAND_FRAME_PARSER_MACROS_SVH

// Checked on every clock edge outside reset.
`define CFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CFP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== sv/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Types, codes and opcode table of the command frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_MISSING = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   // parser phase
   typedef enum logic [1:0] {
      PH_OPCODE  = 2'd0,
      PH_COLLECT = 2'd1,
      PH_SKIP    = 2'd2
   } phase_type;

   localparam int unsigned PARAM_BYTES_MAX = 4;
   localparam int unsigned PARAM_CNT_W     = 3;

   typedef struct packed {
      logic                   known;
      logic [PARAM_CNT_W-1:0] args;
   } op_info_type;

   // opcode table: known flag and parameter byte count
   function automatic op_info_type op_lookup(input logic [7:0] code);
      op_info_type info;
      info = '{known: 1'b1, args: 3'd0};
      case (code) inside
         8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
         8'h0b, 8'h0c, 8'h0e, 8'h0f, 8'h10, 8'h14, 8'h15, 8'h16, 8'h17: begin
            info.args = 3'd1;
         end
         8'h13, 8'h19: begin
            info.args = 3'd2;
         end
         8'h88: begin
            info.args = 3'd4;
         end
         8'h18, 8'h20, 8'h21, 8'h80, 8'h81, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
         8'h99: begin
            info.args = 3'd0;
         end
         default: begin
            info.known = 1'b0;
         end
      endcase
      return info;
   endfunction

endpackage

`default_nettype wire

// ===== sv/command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// command_frame_parser
// Byte-serial parser for downlink command frames.
// ----------------------------------------------------------------------------
// Takes one frame byte per request together with the count of frame bytes
// left (this one included, 1 = last byte) and reports at most one result per
// byte: a complete command with its 0, 1, 2 or 4 parameter bytes (first byte
// received in bits 7:0), a missing-parameter result when an opcode's
// parameters do not fit in the rest of the frame (parsing then goes on with
// the next byte as an opcode), or an unknown-opcode result, after which the
// rest of the frame is skipped. Requests with bytes_left of zero are dropped.
// Throughput is one byte per clock unless the output stalls; a byte is held
// in an input register, classified by a single opcode-table lookup and state
// update, and its result is then registered in the output register, from
// which it is offered.
// Input and output are decoupled by those registers: a new byte is taken
// while a finished result waits, and only a stall on the output with both
// registers full holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_parser
   import cfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] bytes_left
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,   // [7:0] opcode, [39:8] param_bytes,
                                         // [42:40] param_count, [47:43] zero
   output      logic [1:0]  rsp_tuser    // [1:0] status
);

   // ---------------- input register ----------------
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic [7:0] s1_left_ff, s1_left_in;
   logic       advance;

   // the held byte moves on whenever the result register can take a result
   assign advance    = s1_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_left_in  = s1_left_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata[7:0];
         s1_left_in  = req_tdata[15:8];
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_byte_ff <= s1_byte_in;
      s1_left_ff <= s1_left_in;
   end

   // ---------------- parser state ----------------
   phase_type              phase_ff, phase_in;
   logic [7:0]             held_op_ff, held_op_in;
   logic [31:0]            gathered_ff, gathered_in;
   logic [PARAM_CNT_W-1:0] needed_ff, needed_in;
   logic [PARAM_CNT_W-1:0] total_ff, total_in;

   // result of the current byte
   logic                   emit;
   status_type             res_status;
   logic [7:0]             res_op;
   logic [31:0]            res_params;
   logic [PARAM_CNT_W-1:0] res_count;

   op_info_type            info;
   logic [PARAM_CNT_W-1:0] pos_full;
   logic [1:0]             pos;

   assign info     = op_lookup(s1_byte_ff);
   assign pos_full = total_ff - needed_ff;
   assign pos      = pos_full[1:0];

   always_comb begin
      phase_in    = phase_ff;
      held_op_in  = held_op_ff;
      gathered_in = gathered_ff;
      needed_in   = needed_ff;
      total_in    = total_ff;
      emit        = 1'b0;
      res_status  = ST_DONE;
      res_op      = s1_byte_ff;
      res_params  = '0;
      res_count   = '0;

      if (s1_left_ff != 8'd0) begin
         case (phase_ff)
            PH_COLLECT: begin
               // parameter byte, taken whatever nonzero bytes_left says
               gathered_in = gathered_ff | (32'(s1_byte_ff) << {pos, 3'b000});
               needed_in   = needed_ff - 3'd1;
               if (needed_in == '0) begin
                  phase_in   = PH_OPCODE;
                  emit       = 1'b1;
                  res_status = ST_DONE;
                  res_op     = held_op_ff;
                  res_params = gathered_in;
                  res_count  = total_ff;
               end
            end
            PH_SKIP: begin
               if (s1_left_ff == 8'd1) begin
                  phase_in = PH_OPCODE;
               end
            end
            default: begin
               // opcode byte (unused phase code lands here too)
               phase_in = PH_OPCODE;
               emit     = 1'b1;
               if (!info.known) begin
                  res_status = ST_UNKNOWN;
                  if (s1_left_ff > 8'd1) begin
                     phase_in = PH_SKIP;
                  end
               end else if ({5'd0, info.args} >= s1_left_ff) begin
                  res_status = ST_MISSING;
               end else if (info.args == '0) begin
                  res_status = ST_DONE;
               end else begin
                  emit        = 1'b0;
                  held_op_in  = s1_byte_ff;
                  gathered_in = '0;
                  total_in    = info.args;
                  needed_in   = info.args;
                  phase_in    = PH_COLLECT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OPCODE;
         held_op_ff  <= '0;
         gathered_ff <= '0;
         needed_ff   <= '0;
         total_ff    <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         held_op_ff  <= held_op_in;
         gathered_ff <= gathered_in;
         needed_ff   <= needed_in;
         total_ff    <= total_in;
      end
   end

   // ---------------- result register ----------------
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [7:0]             rsp_op_ff, rsp_op_in;
   logic [31:0]            rsp_params_ff, rsp_params_in;
   logic [PARAM_CNT_W-1:0] rsp_count_ff, rsp_count_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_op_in     = rsp_op_ff;
      rsp_params_in = rsp_params_ff;
      rsp_count_in  = rsp_count_ff;
      if (advance) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_status_in = res_status;
            rsp_op_in     = res_op;
            rsp_params_in = res_params;
            rsp_count_in  = res_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_op_ff     <= rsp_op_in;
      rsp_params_ff <= rsp_params_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_count_ff, rsp_params_ff, rsp_op_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// ===== sv/cfp_checker.sv =====
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks on the command frame parser, bound into every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_frame_parser_macros.svh"

module cfp_checker
   import cfp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // no result straight out of reset
   `CFP_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) |-> !rsp_tvalid, "result valid after reset")

   // a stalled result holds
   `CFP_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // missing and unknown results carry no parameters
   `CFP_ASSERT(a_no_params, rsp_tvalid && (rsp_tuser != ST_DONE) |-> (rsp_tdata[42:8] == 35'd0), "parameters on a failed command")

   // parameter count only 0, 1, 2 or 4, unused bytes zero
   `CFP_ASSERT(a_count_ok, rsp_tvalid |-> (rsp_tdata[42:40] == 3'd0 && rsp_tdata[39:8] == 32'd0) || (rsp_tdata[42:40] == 3'd1 && rsp_tdata[39:16] == 24'd0) || (rsp_tdata[42:40] == 3'd2 && rsp_tdata[39:24] == 16'd0) || rsp_tdata[42:40] == 3'd4, "bad parameter count")

   // a byte is always taken while nothing is held
   `CFP_ASSERT(a_ready_free, !rsp_tvalid && $past(!req_tvalid) |-> req_tready, "input stalled with both registers free")

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (.*);

`default_nettype wire

// ===== sim/command_frame_parser_test.sv =====
// ----------------------------------------------------------------------------
// command_frame_parser_test
// Self-checking bench for the byte-serial command frame parser.
// ----------------------------------------------------------------------------
// Byte requests come from a queue and go through a clocked driver. An
// independent parser model, with its own opcode table, predicts the result
// of every accepted byte. A clocked monitor checks each result against the
// oldest prediction. A directed frame set comes first. Random frames follow:
// mostly well-formed command frames, plus truncated frames with large byte
// counts and raw noise, under each of three back-pressure profiles in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_frame_parser_test;
   import cfp_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 7;
   localparam int WATCHDOG_LIMIT = 500;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES   = 10;
   localparam int RANDOM_PER_PHASE = 310;
   localparam int UNKNOWN_OPCODE = -1;

   // one frame byte as it travels on req_tdata
   typedef struct packed {
      logic [7:0] bytes_left;
      logic [7:0] data_byte;
   } frame_byte_type;

   // one parser result
   typedef struct {
      status_type  status;
      logic [7:0]  opcode;
      logic [31:0] param_bytes;
      logic [2:0]  param_count;
   } command_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [7:0] data_byte, [15:8] bytes_left
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [7:0] opcode, [39:8] param_bytes,
                                   // [42:40] param_count, [47:43] zero
   logic [1:0]  rsp_tuser;         // [1:0] status

   command_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // bench state
   // ------------------------------------------------------------------------
   frame_byte_type pending_bytes[$];   // requests not yet driven
   frame_byte_type in_flight;          // request currently on the bus
   command_type    expected_cmds[$];   // predicted results, oldest first
   logic [7:0]     known_opcodes[$];   // filled from the opcode table below

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int queued_bytes = 0;            // requests queued that the parser acts on
   int bytes_accepted = 0;
   int results_seen = 0;
   int done_seen = 0;
   int missing_seen = 0;
   int unknown_seen = 0;
   int fail_count = 0;
   int stall_cycles = 0;

   // model parser state
   phase_type   mdl_phase = PH_OPCODE;
   logic [7:0]  mdl_opcode = '0;
   logic [31:0] mdl_params = '0;
   logic [2:0]  mdl_needed = '0;
   logic [2:0]  mdl_total = '0;

   // ------------------------------------------------------------------------
   // opcode table: parameter byte count, or UNKNOWN_OPCODE
   // ------------------------------------------------------------------------
   function automatic int param_len(input logic [7:0] code);
      case (code)
         8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
         8'h0a, 8'h0b, 8'h0c, 8'h0e, 8'h0f, 8'h10, 8'h14, 8'h15, 8'h16,
         8'h17: return 1;
         8'h13, 8'h19: return 2;
         8'h88: return 4;
         8'h18, 8'h20, 8'h21, 8'h80, 8'h81, 8'h83, 8'h84, 8'h85, 8'h86,
         8'h87, 8'h99: return 0;
         default: return UNKNOWN_OPCODE;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // parser model: advance on one accepted byte, queue its result if any
   // ------------------------------------------------------------------------
   task automatic parse_byte(input frame_byte_type b);
      int need;
      int pos;
      // zero count: dropped in every phase, state untouched
      if (b.bytes_left == 0) return;
      case (mdl_phase)
         PH_COLLECT: begin
            // parameters are taken whatever nonzero count is given
            pos = int'(mdl_total) - int'(mdl_needed);
            mdl_params = mdl_params | (32'(b.data_byte) << (8 * pos));
            mdl_needed = mdl_needed - 3'd1;
            if (mdl_needed == 0) begin
               mdl_phase = PH_OPCODE;
               expected_cmds.push_back('{ST_DONE, mdl_opcode, mdl_params, mdl_total});
            end
         end
         PH_SKIP: begin
            if (b.bytes_left == 8'd1) mdl_phase = PH_OPCODE;
         end
         default: begin
            mdl_phase = PH_OPCODE;
            need = param_len(b.data_byte);
            if (need == UNKNOWN_OPCODE) begin
               // on the last byte there is nothing left to skip
               if (b.bytes_left > 8'd1) mdl_phase = PH_SKIP;
               expected_cmds.push_back('{ST_UNKNOWN, b.data_byte, 32'd0, 3'd0});
            end else if (need >= int'(b.bytes_left)) begin
               // parameters do not fit: report, keep parsing opcodes
               expected_cmds.push_back('{ST_MISSING, b.data_byte, 32'd0, 3'd0});
            end else if (need == 0) begin
               expected_cmds.push_back('{ST_DONE, b.data_byte, 32'd0, 3'd0});
            end else begin
               mdl_opcode = b.data_byte;
               mdl_params = '0;
               mdl_total  = 3'(need);
               mdl_needed = 3'(need);
               mdl_phase  = PH_COLLECT;
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // driver: one request at a time, held until accepted
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(in_flight);
            bytes_accepted += 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               in_flight = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= in_flight;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: random back-pressure, check each accepted result
   // ------------------------------------------------------------------------
   task automatic check_result();
      command_type want;
      status_type  got_status;
      got_status = status_type'(rsp_tuser);
      results_seen += 1;
      if (expected_cmds.size() == 0) begin
         $error("result with nothing expected: status %0d opcode %02h",
                rsp_tuser, rsp_tdata[7:0]);
         fail_count += 1;
         return;
      end
      want = expected_cmds.pop_front();
      case (want.status)
         ST_DONE:    done_seen += 1;
         ST_MISSING: missing_seen += 1;
         default:    unknown_seen += 1;
      endcase
      if (got_status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, rsp_tuser);
         fail_count += 1;
      end
      if (rsp_tdata[7:0] !== want.opcode) begin
         $error("opcode: expected %02h, got %02h", want.opcode, rsp_tdata[7:0]);
         fail_count += 1;
      end
      if (rsp_tdata[39:8] !== want.param_bytes) begin
         $error("param_bytes: expected %08h, got %08h", want.param_bytes,
                rsp_tdata[39:8]);
         fail_count += 1;
      end
      if (rsp_tdata[42:40] !== want.param_count) begin
         $error("param_count: expected %0d, got %0d", want.param_count,
                rsp_tdata[42:40]);
         fail_count += 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: counts cycles with work outstanding and no handshake
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_bytes.size() == 0 && !req_tvalid && expected_cmds.size() == 0)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_cmds.size());
      $display("** command_frame_parser: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] data, input logic [7:0] left);
      pending_bytes.push_back('{bytes_left: left, data_byte: data});
      if (left != 0) queued_bytes += 1;
   endtask

   // Command bytes with counts from start down; start > len truncates the frame.
   task automatic add_frame(input int len, input int start);
      int idx;
      int args;
      logic [7:0] op;
      idx = 0;
      while (idx < len) begin
         if ($urandom_range(0, 99) < 85)
            op = known_opcodes[$urandom_range(0, known_opcodes.size() - 1)];
         else
            op = 8'($urandom_range(0, 255));
         add_byte(op, 8'(start - idx));
         idx += 1;
         args = param_len(op);
         for (int k = 0; k < args && idx < len; k++) begin
            add_byte(8'($urandom_range(0, 255)), 8'(start - idx));
            idx += 1;
         end
      end
   endtask

   task automatic add_random(input int count);
      int goal;
      int pick;
      int len;
      goal = queued_bytes + count;
      while (queued_bytes < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            len = $urandom_range(1, 16);
            add_frame(len, len);
         end else if (pick < 90) begin
            // broken frame with a large count, never reaching the last byte
            add_frame($urandom_range(1, 8), $urandom_range(128, 255));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               add_byte(8'($urandom_range(0, 255)),
                        ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      for (int c = 0; c < 256; c++) begin
         if (param_len(8'(c)) != UNKNOWN_OPCODE) known_opcodes.push_back(8'(c));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // first profile: sender idles lightly, receiver heavily
      @(negedge clock);
      send_idle_pct = 22;
      recv_idle_pct = 51;

      // directed frames
      add_byte(8'h18, 8'd1);                               // lone zero-param opcode
      add_byte(8'h01, 8'd2);  add_byte(8'hff, 8'd1);       // one param, max value
      add_byte(8'h88, 8'd5);  add_byte(8'h11, 8'd4);       // four params, low first
      add_byte(8'h22, 8'd3);  add_byte(8'h33, 8'd2);
      add_byte(8'hff, 8'd1);
      add_byte(8'h88, 8'd4);                               // four params do not fit
      add_byte(8'h99, 8'd3);                               // parsed as opcode again
      add_byte(8'h13, 8'd2);                               // two params, one byte left
      add_byte(8'h20, 8'd1);
      add_byte(8'h00, 8'd3);                               // unknown: skip the rest
      add_byte(8'hff, 8'd2);  add_byte(8'h18, 8'd1);
      add_byte(8'hff, 8'd1);                               // unknown on last byte
      add_byte(8'h80, 8'd1);                               // nothing skipped
      add_byte(8'h19, 8'd200);                             // params ignore the count
      add_byte(8'hab, 8'd255);
      add_byte(8'h7f, 8'd0);                               // dropped while collecting
      add_byte(8'hcd, 8'd7);
      add_byte(8'h7f, 8'd3);                               // unknown, then skip
      add_byte(8'h00, 8'd0);                               // dropped while skipping
      add_byte(8'h01, 8'd1);                               // last byte ends the skip
      add_byte(8'h18, 8'd0);                               // dropped opcode

      add_random(RANDOM_PER_PHASE);
      wait_drained();

      // second profile: roles swapped
      send_idle_pct = 51;
      recv_idle_pct = 22;
      add_random(RANDOM_PER_PHASE);
      wait_drained();

      // third profile: full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(RANDOM_PER_PHASE);
      wait_drained();

      while (expected_cmds.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d bytes accepted, %0d results checked", bytes_accepted, results_seen);
      $display("complete %0d, missing params %0d, unknown opcode %0d, errors %0d",
               done_seen, missing_seen, unknown_seen, fail_count);
      if (fail_count == 0) begin
         $display("** command_frame_parser: PASSED **");
      end else begin
         $display("** command_frame_parser: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cfp_pkg.sv
sv/command_frame_parser.sv
sv/cfp_checker.sv
sim/command_frame_parser_test.sv
